[hdl/assert_macros.svh]
// Assertion macros used by the date info RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted (active low).
`define GDI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with no reset qualification.
`define GDI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/gdi_pkg.sv]
// Package for the date info core: stage payload types, calendar tables, divide constants.
`timescale 1ns / 1ps

package gdi_pkg;

    // Reciprocal of 25: q = (x * 5243) >> 17, exact for x < 4096
    localparam logic [12:0] DIV25_MUL = 13'd5243;
    // Reciprocal of 7: q = (x * 18725) >> 17, exact for x < 16384
    localparam logic [14:0] DIV7_MUL  = 15'd18725;
    // Reciprocal of 7 for day of year: q = (x * 293) >> 11, exact for x < 512
    localparam logic [8:0]  WEEK_MUL  = 9'd293;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [13:0] yy;       // year, less one for Jan/Feb
        logic [7:0]  y_div100; // year / 100
        logic [7:0]  yy_div100; // yy / 100
    } gdi_s1_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic        ok;
        logic [8:0]  doy;
        logic [13:0] wsum;     // weekday sum before mod 7
    } gdi_s2_t;

    // Result beat
    typedef struct packed {
        logic        date_ok;
        logic [8:0]  day_number;
        logic [2:0]  weekday;
        logic [5:0]  week_number;
    } gdi_res_t;

    // Days in month for a common year; 0 for codes that are not months
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // Days before the first of month m in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Sakamoto month offset, indexed by month number
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/gregorian_date_info_core.sv]
// Top level of the Gregorian date info core: three compute stages and an output skid.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_day[5:0], s_month[3:0], s_year[13:0]
//  m_      | out       | m_valid / m_ready  | m_date_ok, m_day_number[8:0],
//          |           |                    | m_weekday[2:0], m_week_number[5:0]
//
// One date per cycle sustained while m_ready stays high; an accepted input beat passes
// the three compute stage registers, then the output register of the skid buffer.
// The two constant-reciprocal multipliers of stages 1 and 3 set the cycle time.
// aresetn is synchronous, active low, and clears all valid bits; no setup pass.
// A stall on m_ready fills the skid slot, then backs up through the stages; s_ready
// falls only once every stage holds a beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gregorian_date_info_core
    import gdi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_date_ok,
    output logic [8:0]  m_day_number,
    output logic [2:0]  m_weekday,
    output logic [5:0]  m_week_number
);

    logic     s1_valid;
    logic     s1_ready;
    gdi_s1_t  s1_data;
    logic     s2_valid;
    logic     s2_ready;
    gdi_s2_t  s2_data;
    logic     s3_valid;
    logic     s3_ready;
    gdi_res_t s3_data;
    gdi_res_t res;

    gdi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_day    (s_day),
        .in_month  (s_month),
        .in_year   (s_year),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    gdi_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    gdi_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    gdi_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res)
    );

    assign m_date_ok     = res.date_ok;
    assign m_day_number  = res.day_number;
    assign m_weekday     = res.weekday;
    assign m_week_number = res.week_number;

    // Invalid dates carry all-zero result fields
    `GDI_ASSERT_CLK(a_invalid_zero, aclk, aresetn,
        (m_valid && !m_date_ok) |-> (m_day_number == 9'd0 && m_weekday == 3'd0 &&
        m_week_number == 6'd0), "invalid date with nonzero result fields")

    // Valid dates: day in 1..366, weekday in 0..6
    `GDI_ASSERT_CLK(a_valid_range, aclk, aresetn,
        (m_valid && m_date_ok) |-> (m_day_number != 9'd0 && m_day_number <= 9'd366 &&
        m_weekday <= 3'd6), "valid date with result out of range")

    // Week number brackets the day of year: 7*(w-1) <= doy < 7*w
    `GDI_ASSERT_CLK(a_week_bracket, aclk, aresetn,
        (m_valid && m_date_ok) |-> ((10'(m_week_number) - 10'd1) * 10'd7 <=
        10'(m_day_number) && 10'(m_day_number) < 10'(m_week_number) * 10'd7),
        "week number does not match day of year")

    // Input back-pressure only when the whole pipe, output included, is full
    `GDI_ASSERT_CLK(a_full_on_stall, aclk, aresetn,
        !s_ready |-> (m_valid && s1_valid && s2_valid && s3_valid),
        "input stalled while the pipeline has room")

endmodule

[hdl/gdi_front.sv]
// Stage 1: year adjust and divide-by-100 of the year and the adjusted year.
`timescale 1ns / 1ps

module gdi_front
    import gdi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  in_day,
    input  logic [3:0]  in_month,
    input  logic [13:0] in_year,
    output logic        out_valid,
    input  logic        out_ready,
    output gdi_s1_t     out_data
);

    logic        valid_reg;
    gdi_s1_t     data_reg;
    gdi_s1_t     data_next;
    logic [24:0] y_prod;
    logic [24:0] yy_prod;

    // Stage advances when empty or when downstream takes the beat
    assign in_ready = !valid_reg || out_ready;

    // Jan and Feb count toward the previous year; divide by 100 as (x/4)/25
    always_comb begin
        data_next.day   = in_day;
        data_next.month = in_month;
        data_next.year  = in_year;
        data_next.yy    = (in_month < 4'd3) ? in_year - 14'd1 : in_year;
        y_prod  = 25'(in_year[13:2]) * 25'(DIV25_MUL);
        yy_prod = 25'(data_next.yy[13:2]) * 25'(DIV25_MUL);
        data_next.y_div100  = y_prod[24:17];
        data_next.yy_div100 = yy_prod[24:17];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/gdi_calc.sv]
// Stage 2: leap year, range checks, day of year and the weekday sum.
`timescale 1ns / 1ps

module gdi_calc
    import gdi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  gdi_s1_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output gdi_s2_t out_data
);

    logic       valid_reg;
    gdi_s2_t    data_reg;
    gdi_s2_t    data_next;
    logic [11:0] back100;
    logic       div100;
    logic       leap;
    logic [4:0] max_day;
    logic       year_ok;
    logic       month_ok;
    logic       day_ok;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // Leap: divisible by 4, and not by 100 unless by 400 (y/100 divisible by 4)
        back100 = 12'(in_data.y_div100) * 12'd25;
        div100  = (in_data.year[13:2] == back100);
        leap    = (in_data.year[1:0] == 2'd0) &&
                  (!div100 || (in_data.y_div100[1:0] == 2'd0));

        // Month length with the leap day in February
        max_day = month_len(in_data.month);
        if ((in_data.month == MONTH_FEB) && leap) begin
            max_day = 5'd29;
        end

        year_ok  = (in_data.year != 14'd0) && (in_data.year <= YEAR_MAX);
        month_ok = (in_data.month >= MONTH_JAN) && (in_data.month <= MONTH_DEC);
        day_ok   = (in_data.day != 6'd0) && (in_data.day <= 6'(max_day));
        data_next.ok = year_ok && month_ok && day_ok;

        // Day of year, leap day counted after February
        data_next.doy = days_before(in_data.month) + 9'(in_data.day) +
                        9'((in_data.month > MONTH_FEB) && leap);

        // yy + yy/4 - yy/100 + yy/400 + offset + day
        data_next.wsum = in_data.yy + 14'(in_data.yy[13:2]) -
                         14'(in_data.yy_div100) + 14'(in_data.yy_div100[7:2]) +
                         14'(month_offset(in_data.month)) + 14'(in_data.day);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/gdi_finish.sv]
// Stage 3: weekday mod 7, week of year, zeroing of invalid dates.
`timescale 1ns / 1ps

module gdi_finish
    import gdi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  gdi_s2_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output gdi_res_t out_data
);

    logic        valid_reg;
    gdi_res_t    data_reg;
    gdi_res_t    data_next;
    logic [28:0] wd_prod;
    logic [13:0] wd_quot;
    logic [13:0] wd_rem;
    logic [17:0] wk_prod;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // Weekday: remainder of the sum by 7 through a reciprocal multiply
        wd_prod = 29'(in_data.wsum) * 29'(DIV7_MUL);
        wd_quot = 14'(wd_prod[28:17]);
        wd_rem  = in_data.wsum - 14'(wd_quot * 14'd7);
        // Week of year: doy / 7 + 1
        wk_prod = 18'(in_data.doy) * 18'(WEEK_MUL);

        if (in_data.ok) begin
            data_next.date_ok     = 1'b1;
            data_next.day_number  = in_data.doy;
            data_next.weekday     = wd_rem[2:0];
            data_next.week_number = 6'(wk_prod[17:11]) + 6'd1;
        end else begin
            data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/gdi_skid.sv]
// Output skid buffer: registered ready toward the pipeline, registered result beat.
`timescale 1ns / 1ps

module gdi_skid
    import gdi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  gdi_res_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output gdi_res_t out_data
);

    logic     out_valid_reg;
    gdi_res_t out_data_reg;
    logic     skid_valid_reg;
    gdi_res_t skid_data_reg;
    logic     out_free;
    logic     take;

    // Ready depends only on the skid slot being empty
    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign take     = in_valid && !skid_valid_reg;

    // Control: output slot refills from skid first, then from the input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (take) begin
                out_data_reg <= in_data;
            end
        end else if (take) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
